// ===== rtl/cft_pkg.sv =====
package cft_pkg;

  // default size of the received map
  localparam int MAX_FRAGMENTS_DEF = 256;

  // depth of the queues between front, back and result side
  localparam int QUEUE_DEPTH = 4;

  // reflected crc-32
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_XOR  = 32'hFFFF_FFFF;

  typedef logic [31:0] crc_tab_t [256];

  // byte-wise table, built at elaboration
  function automatic crc_tab_t crc_tab_gen();
    crc_tab_t    tab;
    logic [31:0] c;
    for (int n = 0; n < 256; n++) begin
      c = 32'(n);
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      tab[n] = c;
    end
    return tab;
  endfunction

  localparam crc_tab_t CRC_TAB = crc_tab_gen();

  // one input byte with its fragment header
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic [15:0] fragment_number;
    logic [15:0] fragment_total;
    logic [31:0] expected_crc;
    logic        same_transfer;
  } in_t;

  // one fragment result
  typedef struct packed {
    logic       crc_good;
    logic       newly_stored;
    logic       index_bad;
    logic [8:0] received_count;
    logic       transfer_done;
  } out_t;

  // classified fragment, front to back
  typedef struct packed {
    logic        good;
    logic        same;
    logic        bad;
    logic [15:0] number;
    logic [15:0] total;
  } frag_t;

endpackage

// ===== rtl/cft_fifo.sv =====
module cft_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             full;
  logic             do_push, do_pop;

  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];
  assign count = count_r;

  // pointer and fill level update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== rtl/cft_front.sv =====
module cft_front #(
  parameter int MAX_FRAGMENTS = cft_pkg::MAX_FRAGMENTS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          byte_acc,
  input  cft_pkg::in_t  in_item,
  output logic          frag_push,
  output cft_pkg::frag_t frag
);

  import cft_pkg::*;

  logic [31:0] crc_r, crc_nxt;
  logic [31:0] crc_start;

  // one table step per byte
  assign crc_start = in_item.first_byte ? CRC_INIT : crc_r;
  assign crc_nxt   = CRC_TAB[crc_start[7:0] ^ in_item.data_byte] ^ {8'h00, crc_start[31:8]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= '0;
    end else if (byte_acc) begin
      crc_r <= crc_nxt;
    end
  end

  // classify the fragment on its last byte
  assign frag_push = byte_acc && in_item.last_byte;

  always_comb begin
    frag.good   = ((crc_nxt ^ CRC_XOR) == in_item.expected_crc);
    frag.same   = in_item.same_transfer;
    frag.bad    = (in_item.fragment_number == 16'd0) ||
                  (in_item.fragment_number > 16'(MAX_FRAGMENTS));
    frag.number = in_item.fragment_number;
    frag.total  = in_item.fragment_total;
  end

endmodule

// ===== rtl/cft_back.sv =====
module cft_back #(
  parameter int MAX_FRAGMENTS = cft_pkg::MAX_FRAGMENTS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   frag_empty,
  input  cft_pkg::frag_t                         frag_head,
  output logic                                   frag_pop,
  input  logic [$clog2(cft_pkg::QUEUE_DEPTH+1)-1:0] res_count,
  output logic                                   res_push,
  output cft_pkg::out_t                          res,
  output logic                                   clr_busy
);

  import cft_pkg::*;

  localparam int IW = $clog2(MAX_FRAGMENTS);
  localparam int CW = $clog2(MAX_FRAGMENTS + 1);
  localparam int QW = $clog2(QUEUE_DEPTH + 1) + 1;

  logic          map_mem [MAX_FRAGMENTS];
  logic          busy_r;
  logic [IW-1:0] clr_idx_r;
  logic [IW-1:0] head_slot;
  logic          b_vld_r;
  frag_t         b_frag_r;
  logic [IW-1:0] b_slot_r;
  logic          rd_bit_r;
  logic          fwd_vld_r;
  logic [IW-1:0] fwd_slot_r;
  logic [CW-1:0] count_r, count_nxt;
  logic          done_r, done_nxt;
  logic          take, seen, fresh;

  assign clr_busy  = busy_r;
  assign head_slot = IW'(frag_head.number - 16'd1);

  // take a fragment only when the result queue has room for it
  assign frag_pop = !frag_empty && !busy_r &&
                    ((QW'(res_count) + QW'(b_vld_r)) < QW'(QUEUE_DEPTH));

  // map lookup stage
  always_ff @(posedge clk) begin
    if (frag_pop) begin
      rd_bit_r <= map_mem[head_slot];
      b_frag_r <= frag_head;
      b_slot_r <= head_slot;
    end
  end

  // update stage, forwarding the write of the previous cycle
  always_comb begin
    take      = b_frag_r.good && b_frag_r.same && !b_frag_r.bad;
    seen      = rd_bit_r || (fwd_vld_r && (fwd_slot_r == b_slot_r));
    fresh     = b_vld_r && take && !seen;
    count_nxt = fresh ? count_r + CW'(1) : count_r;
    done_nxt  = done_r || (b_vld_r && (16'(count_nxt) == b_frag_r.total));
  end

  assign res_push = b_vld_r;

  always_comb begin
    res.crc_good       = b_frag_r.good;
    res.newly_stored   = fresh;
    res.index_bad      = b_frag_r.bad;
    res.received_count = 9'(count_nxt);
    res.transfer_done  = done_nxt;
  end

  // control state and map clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      clr_idx_r <= '0;
      b_vld_r   <= 1'b0;
      fwd_vld_r <= 1'b0;
      count_r   <= '0;
      done_r    <= 1'b0;
    end else begin
      if (busy_r) begin
        clr_idx_r <= clr_idx_r + IW'(1);
        if (clr_idx_r == IW'(MAX_FRAGMENTS - 1)) begin
          busy_r <= 1'b0;
        end
      end
      b_vld_r   <= frag_pop;
      fwd_vld_r <= fresh;
      count_r   <= count_nxt;
      done_r    <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fwd_slot_r <= b_slot_r;
  end

  // received map write port
  always_ff @(posedge clk) begin
    if (busy_r) begin
      map_mem[clr_idx_r] <= 1'b0;
    end else if (fresh) begin
      map_mem[b_slot_r] <= 1'b1;
    end
  end

endmodule

// ===== rtl/crc_checked_fragment_tracker.sv =====
// Fragment tracker with CRC-32 check. Payload bytes enter one per cycle
// through push/full, each with its fragment header; the front runs a
// reflected CRC-32 one table step per byte and, on the last byte of a
// fragment, queues a classified record. The back marks the fragment in a
// received map held in a memory (read one cycle, written the next) and
// counts distinct good fragments; one result per fragment leaves through
// empty/pop. Bytes are taken every cycle while the result side keeps
// popping. After reset the map is cleared one entry per cycle, and full
// stays high until that clearing pass is done.
module crc_checked_fragment_tracker #(
  parameter int MAX_FRAGMENTS = cft_pkg::MAX_FRAGMENTS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  cft_pkg::in_t  in_data,
  output logic          empty,
  input  logic          pop,
  output cft_pkg::out_t out_data
);

  import cft_pkg::*;

  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  logic           byte_acc;
  logic           frag_push;
  frag_t          frag_in;
  logic           frag_full;
  logic [QCW-1:0] frag_count;
  logic           frag_empty;
  logic           frag_pop;
  logic [$bits(frag_t)-1:0] frag_rd;
  frag_t          frag_head;
  logic           res_push;
  out_t           res;
  logic [QCW-1:0] res_count;
  logic [$bits(out_t)-1:0]  res_rd;
  logic           clr_busy;

  // input transfer
  assign full     = clr_busy || frag_full;
  assign byte_acc = push && !full;

  cft_front #(
    .MAX_FRAGMENTS(MAX_FRAGMENTS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_acc (byte_acc),
    .in_item  (in_data),
    .frag_push(frag_push),
    .frag     (frag_in)
  );

  // fragment queue between front and back
  cft_fifo #(
    .WIDTH($bits(frag_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_frag_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (frag_push),
    .wdata(frag_in),
    .pop  (frag_pop),
    .rdata(frag_rd),
    .empty(frag_empty),
    .count(frag_count)
  );

  assign frag_full = (frag_count == QCW'(QUEUE_DEPTH));
  assign frag_head = frag_t'(frag_rd);

  cft_back #(
    .MAX_FRAGMENTS(MAX_FRAGMENTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .frag_empty(frag_empty),
    .frag_head (frag_head),
    .frag_pop  (frag_pop),
    .res_count (res_count),
    .res_push  (res_push),
    .res       (res),
    .clr_busy  (clr_busy)
  );

  // result queue; the back only issues when room is reserved
  cft_fifo #(
    .WIDTH($bits(out_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (res_push),
    .wdata(res),
    .pop  (pop),
    .rdata(res_rd),
    .empty(empty),
    .count(res_count)
  );

  assign out_data = out_t'(res_rd);

endmodule

// ===== verif/frag_result_check.sv =====
`timescale 1ns / 100ps

module frag_result_check (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic          full,
  input  cft_pkg::in_t  in_data,
  input  logic          empty,
  input  logic          pop,
  input  cft_pkg::out_t out_data,
  output int            fails,
  output int            waiting,
  output int            results_seen,
  output logic [8:0]    stored_now,
  output logic          done_now
);

  import cft_pkg::*;

  localparam int MAP_SIZE = MAX_FRAGMENTS_DEF;

  // predicted tracker state
  logic [31:0] crc_acc;
  bit          seen_map [MAP_SIZE];
  logic [8:0]  frag_count;
  logic        done_seen;
  out_t        fragment_results [$];
  int          fail_cnt = 0;
  int          result_cnt = 0;

  // one reflected crc-32 step over a byte
  function automatic logic [31:0] crc_advance(logic [31:0] c, logic [7:0] d);
    logic [31:0] r;
    r = c ^ {24'h0, d};
    repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  // fold one accepted byte into the state, queue a result on a last byte
  task automatic track_byte(input in_t b);
    out_t r;
    logic ok;
    logic oor;
    logic fresh;
    crc_acc = crc_advance(b.first_byte ? CRC_INIT : crc_acc, b.data_byte);
    if (b.last_byte) begin
      ok    = ((crc_acc ^ CRC_XOR) == b.expected_crc);
      oor   = (b.fragment_number == 16'd0) || (int'(b.fragment_number) > MAP_SIZE);
      fresh = 1'b0;
      if (ok && b.same_transfer && !oor && !seen_map[b.fragment_number - 1]) begin
        seen_map[b.fragment_number - 1] = 1'b1;
        if (int'(frag_count) < MAP_SIZE) frag_count++;
        fresh = 1'b1;
      end
      if (16'(frag_count) == b.fragment_total) done_seen = 1'b1;
      r.crc_good       = ok;
      r.newly_stored   = fresh;
      r.index_bad      = oor;
      r.received_count = frag_count;
      r.transfer_done  = done_seen;
      fragment_results.push_back(r);
    end
  endtask

  // compare one popped result with the oldest prediction
  task automatic match_result(input out_t got);
    out_t want;
    result_cnt++;
    if (fragment_results.size() == 0) begin
      $error("unexpected result: good %0b new %0b bad %0b count %0d done %0b",
             got.crc_good, got.newly_stored, got.index_bad, got.received_count,
             got.transfer_done);
      fail_cnt++;
    end else begin
      want = fragment_results.pop_front();
      if (got.crc_good !== want.crc_good) begin
        $error("crc_good: expected %0b, got %0b", want.crc_good, got.crc_good);
        fail_cnt++;
      end
      if (got.newly_stored !== want.newly_stored) begin
        $error("newly_stored: expected %0b, got %0b", want.newly_stored, got.newly_stored);
        fail_cnt++;
      end
      if (got.index_bad !== want.index_bad) begin
        $error("index_bad: expected %0b, got %0b", want.index_bad, got.index_bad);
        fail_cnt++;
      end
      if (got.received_count !== want.received_count) begin
        $error("received_count: expected %0d, got %0d", want.received_count,
               got.received_count);
        fail_cnt++;
      end
      if (got.transfer_done !== want.transfer_done) begin
        $error("transfer_done: expected %0b, got %0b", want.transfer_done, got.transfer_done);
        fail_cnt++;
      end
    end
  endtask

  // watch both channels; result side first so a same-edge byte never matches
  always @(posedge clk) begin
    if (!rst_n) begin
      crc_acc    = '0;
      frag_count = '0;
      done_seen  = 1'b0;
      foreach (seen_map[i]) seen_map[i] = 1'b0;
      fragment_results.delete();
    end else begin
      if (pop && !empty) match_result(out_data);
      if (push && !full) track_byte(in_data);
    end
    fails        <= fail_cnt;
    waiting      <= fragment_results.size();
    results_seen <= result_cnt;
    stored_now   <= frag_count;
    done_now     <= done_seen;
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import cft_pkg::*;

  localparam int RANDOM_BYTES = 1150;
  localparam int IDLE_LIMIT   = 2000;

  typedef enum {CRC_RIGHT, CRC_FLIP, CRC_RANDOM} crc_kind_t;

  logic       clk      = 1'b0;
  logic       rst_n    = 1'b0;
  logic       in_push  = 1'b0;
  logic       in_full;
  in_t        in_data  = '0;
  logic       out_empty;
  logic       out_pop  = 1'b0;
  out_t       out_data;
  int         fails;
  int         waiting;
  int         results_seen;
  logic [8:0] stored_now;
  logic       done_now;

  // sender bookkeeping
  logic [31:0] tx_crc      = '0;
  int          burst_left  = 0;
  int          bytes_sent  = 0;
  int          frags_sent  = 0;
  int          idle_cycles = 0;

  // receiver pattern
  int   pop_left  = 0;
  int   pop_pick;
  logic pop_level = 1'b1;

  always #2 clk = ~clk;

  crc_checked_fragment_tracker dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_push),
    .full     (in_full),
    .in_data  (in_data),
    .empty    (out_empty),
    .pop      (out_pop),
    .out_data (out_data)
  );

  frag_result_check u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (in_push),
    .full         (in_full),
    .in_data      (in_data),
    .empty        (out_empty),
    .pop          (out_pop),
    .out_data     (out_data),
    .fails        (fails),
    .waiting      (waiting),
    .results_seen (results_seen),
    .stored_now   (stored_now),
    .done_now     (done_now)
  );

  // crc over payload, used only to build good and bad fragments
  function automatic logic [31:0] crc_next(logic [31:0] c, logic [7:0] d);
    logic [31:0] r;
    r = c ^ {24'h0, d};
    repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  // one byte transfer, then maybe a gap when the burst runs out
  task automatic send_byte(input in_t b);
    int gap;
    in_data <= b;
    in_push <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    bytes_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // a fragment of len bytes; header fields that matter ride on the last byte
  task automatic send_fragment(input int len, input logic [15:0] num,
                               input logic [15:0] tot, input logic same,
                               input bit opening, input bit closing,
                               input crc_kind_t how, input int fill = -1);
    logic [7:0]  body [$];
    logic [31:0] c;
    in_t         b;
    c = opening ? CRC_INIT : tx_crc;
    for (int i = 0; i < len; i++) begin
      body.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
      c = crc_next(c, body[i]);
    end
    tx_crc = c;
    for (int i = 0; i < len; i++) begin
      b.data_byte  = body[i];
      b.first_byte = opening && (i == 0);
      b.last_byte  = closing && (i == len - 1);
      if (b.last_byte) begin
        b.fragment_number = num;
        b.fragment_total  = tot;
        b.same_transfer   = same;
        case (how)
          CRC_RIGHT: b.expected_crc = c ^ CRC_XOR;
          CRC_FLIP:  b.expected_crc = (c ^ CRC_XOR) ^ (32'h1 << $urandom_range(0, 31));
          default:   b.expected_crc = $urandom;
        endcase
      end else begin
        b.fragment_number = 16'($urandom);
        b.fragment_total  = 16'($urandom);
        b.same_transfer   = 1'($urandom);
        b.expected_crc    = $urandom;
      end
      send_byte(b);
    end
    if (closing) frags_sent++;
  endtask

  // hold the sender until every predicted result has been popped
  task automatic drain_results();
    in_push <= 1'b0;
    do @(posedge clk); while (waiting != 0);
  endtask

  // receiver: runs of pops, short stalls and long stalls
  always @(posedge clk) begin
    if (pop_left == 0) begin
      pop_pick = $urandom_range(0, 99);
      if (pop_pick < 45) begin
        pop_level = 1'b1;
        pop_left  = $urandom_range(1, 40);
      end else if (pop_pick < 85) begin
        pop_level = 1'b0;
        pop_left  = $urandom_range(1, 4);
      end else begin
        pop_level = 1'b0;
        pop_left  = $urandom_range(8, 16);
      end
    end
    pop_left--;
    out_pop <= pop_level;
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[crc_checked_fragment_tracker] ERROR");
        $finish;
      end
    end
  end

  initial begin
    int          stop_at;
    int          pick;
    int          len;
    bit          paused;
    logic [15:0] num;
    logic [15:0] tot;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: index extremes, duplicate, foreign transfer, bad crc,
    // single byte, continuation without first byte, data extremes
    send_fragment(1, 16'd1, 16'hFFFF, 1'b1, 1, 1, CRC_RIGHT);
    send_fragment(2, 16'd256, 16'hFFFF, 1'b1, 1, 1, CRC_RIGHT);
    send_fragment(1, 16'd1, 16'hFFFF, 1'b1, 1, 1, CRC_RIGHT);
    send_fragment(1, 16'd0, 16'hFFFF, 1'b1, 1, 1, CRC_RIGHT);
    send_fragment(1, 16'd257, 16'hFFFF, 1'b1, 1, 1, CRC_FLIP);
    send_fragment(1, 16'hFFFF, 16'hFFFF, 1'b1, 1, 1, CRC_RIGHT);
    send_fragment(1, 16'd5, 16'hFFFF, 1'b0, 1, 1, CRC_RIGHT);
    send_fragment(2, 16'd6, 16'hFFFF, 1'b1, 1, 1, CRC_FLIP);
    send_fragment(2, 16'd7, 16'hFFFF, 1'b1, 1, 0, CRC_RIGHT);
    send_fragment(2, 16'd7, 16'hFFFF, 1'b1, 0, 1, CRC_RIGHT);
    send_fragment(3, 16'd2, 16'hFFFF, 1'b1, 1, 1, CRC_RIGHT, 8'hFF);
    send_fragment(3, 16'd3, 16'hFFFF, 1'b1, 1, 1, CRC_RIGHT, 8'h00);
    drain_results();

    // random: mostly well-formed fragments, plus noise and broken framing
    stop_at = bytes_sent + RANDOM_BYTES;
    paused  = 0;
    while (bytes_sent < stop_at) begin
      if (!paused && bytes_sent > stop_at - RANDOM_BYTES / 2) begin
        drain_results();
        paused = 1;
      end
      pick = $urandom_range(0, 99);
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      num  = 16'($urandom_range(1, 256));
      tot  = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 256))
                                         : 16'($urandom_range(257, 65535));
      if (pick < 70) begin
        send_fragment(len, num, tot, 1'b1, 1, 1, CRC_RIGHT);
      end else if (pick < 80) begin
        send_fragment(len, num, tot, 1'($urandom), 1, 1,
                      ($urandom_range(0, 1) == 0) ? CRC_FLIP : CRC_RANDOM);
      end else if (pick < 88) begin
        send_fragment(len, num, tot, 1'b0, 1, 1, CRC_RIGHT);
      end else if (pick < 94) begin
        num = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(257, 65535));
        send_fragment(len, num, tot, 1'b1, 1, 1,
                      ($urandom_range(0, 1) == 0) ? CRC_RIGHT : CRC_FLIP);
      end else if (pick < 97) begin
        send_fragment(len, num, tot, 1'b1, 1, 0, CRC_RIGHT);
      end else begin
        send_fragment(len, num, tot, 1'b1, 0, 1, CRC_RIGHT);
      end
    end

    // close the transfer: total equal to the count sets done even on a bad crc
    drain_results();
    send_fragment(2, 16'($urandom_range(1, 256)), {7'h0, stored_now}, 1'b1, 1, 1, CRC_FLIP);
    repeat (10) begin
      send_fragment($urandom_range(1, 6), 16'($urandom_range(1, 256)),
                    16'($urandom), 1'b1, 1, 1, CRC_RIGHT);
    end

    drain_results();
    repeat (20) @(posedge clk);

    $display("run covered %0d payload bytes in %0d fragments, %0d results checked",
             bytes_sent, frags_sent, results_seen);
    $display("distinct fragments stored %0d, transfer done flag %0b", stored_now, done_now);
    if (fails == 0) begin
      $display("[crc_checked_fragment_tracker] OK");
    end else begin
      $display("[crc_checked_fragment_tracker] ERROR");
    end
    $finish;
  end

endmodule
